[hdl/qfr_pkg.sv]
// Shared types, widths and codes for the quaternion-from-rotation-matrix block.
package qfr_pkg;

    // Number format of matrix entries and quaternion components
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int LIMIT_W    = DATA_WIDTH - 1;
    localparam int LIMIT_SQ_W = 2 * LIMIT_W;

    // Front end: clamped root argument and numerator magnitudes
    localparam int ARG_W = DATA_WIDTH + 1;
    localparam int MAG_W = DATA_WIDTH + 1;

    // First root and divide
    localparam int SQ_IN_W   = ARG_W + FRAC_BITS + ((ARG_W + FRAC_BITS) % 2);
    localparam int SQ_W      = SQ_IN_W / 2;
    localparam int DEN_W     = SQ_W + 1;
    localparam int DIV1_N_W  = MAG_W + FRAC_BITS;
    // smallest nonzero divisor is 2 * 2^(FRAC_BITS/2)
    localparam int DIV1_Q_W  = DIV1_N_W - (FRAC_BITS / 2 + 1);
    localparam int COMP_W    = DIV1_Q_W;

    // Normalization
    localparam int NORM_W    = 31;
    localparam int SH_W      = $clog2(NORM_W);
    localparam int SSUM1_W   = 2 * COMP_W + 2;
    localparam int NSUM_W    = 2 * NORM_W + 2;
    localparam int NRM_W     = NSUM_W / 2;
    localparam int DIV2_N_W  = NORM_W + FRAC_BITS;
    localparam int DIV2_Q_W  = FRAC_BITS + 1;

    localparam logic signed [DATA_WIDTH-1:0] QUAT_ONE = DATA_WIDTH'(1) << FRAC_BITS;

    // Case codes
    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_X     = 2'd1;
    localparam logic [1:0] CASE_Y     = 2'd2;
    localparam logic [1:0] CASE_Z     = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m00;
        logic signed [DATA_WIDTH-1:0] m01;
        logic signed [DATA_WIDTH-1:0] m02;
        logic signed [DATA_WIDTH-1:0] m10;
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m20;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic [1:0]                   case_taken;
        logic                         degenerate;
    } out_item_t;

    // Classified item: lanes hold the three non-dominant components in x,y,z,w order
    typedef struct packed {
        logic [1:0]            case_taken;
        logic [ARG_W-1:0]      arg;
        logic [2:0]            num_neg;
        logic [2:0][MAG_W-1:0] num_mag;
    } cls_item_t;

endpackage

[hdl/qfr_front.sv]
// Front end: picks the Shepperd case, the root argument and the three numerators.
module qfr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qfr_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qfr_pkg::cls_item_t   out_item
);

    localparam int EW = qfr_pkg::DATA_WIDTH + 2;
    localparam int PW = qfr_pkg::DATA_WIDTH + 1;
    localparam logic signed [EW-1:0] ARG_ONE = EW'(qfr_pkg::QUAT_ONE);

    function automatic logic [qfr_pkg::MAG_W-1:0] mag_of(input logic signed [PW-1:0] v);
        return v[PW-1] ? qfr_pkg::MAG_W'(-v) : qfr_pkg::MAG_W'(v);
    endfunction

    logic signed [EW-1:0] d00, d11, d22, t_sum, arg_s;
    logic signed [PW-1:0] dx, dy, dz, pxy, pxz, pyz;
    logic signed [PW-1:0] n0, n1, n2;
    logic [1:0]           cs;
    qfr_pkg::cls_item_t   item_next;
    logic                 valid_reg;
    qfr_pkg::cls_item_t   item_reg;

    // Trace, diagonal sums and the six off-diagonal combinations
    assign d00   = EW'(in_item.m00);
    assign d11   = EW'(in_item.m11);
    assign d22   = EW'(in_item.m22);
    assign t_sum = d00 + d11 + d22;
    assign dx    = PW'(in_item.m21) - PW'(in_item.m12);
    assign dy    = PW'(in_item.m02) - PW'(in_item.m20);
    assign dz    = PW'(in_item.m10) - PW'(in_item.m01);
    assign pxy   = PW'(in_item.m01) + PW'(in_item.m10);
    assign pxz   = PW'(in_item.m02) + PW'(in_item.m20);
    assign pyz   = PW'(in_item.m12) + PW'(in_item.m21);

    // Case select
    always_comb
    begin
        if (t_sum > 0)
            cs = qfr_pkg::CASE_TRACE;
        else if (d00 > d11 && d00 > d22)
            cs = qfr_pkg::CASE_X;
        else if (d11 > d22)
            cs = qfr_pkg::CASE_Y;
        else
            cs = qfr_pkg::CASE_Z;
    end

    // Root argument and numerators per case
    always_comb
    begin
        case (cs)
            qfr_pkg::CASE_TRACE:
            begin
                arg_s = ARG_ONE + t_sum;
                n0 = dx; n1 = dy; n2 = dz;
            end
            qfr_pkg::CASE_X:
            begin
                arg_s = ARG_ONE + d00 - d11 - d22;
                n0 = pxy; n1 = pxz; n2 = dx;
            end
            qfr_pkg::CASE_Y:
            begin
                arg_s = ARG_ONE + d11 - d00 - d22;
                n0 = pxy; n1 = pyz; n2 = dy;
            end
            default:
            begin
                arg_s = ARG_ONE + d22 - d00 - d11;
                n0 = pxz; n1 = pyz; n2 = dz;
            end
        endcase
    end

    always_comb
    begin
        item_next.case_taken = cs;
        // negative argument from a non-orthogonal matrix clamps to zero
        item_next.arg        = arg_s[EW-1] ? '0 : arg_s[qfr_pkg::ARG_W-1:0];
        item_next.num_neg    = {n2[PW-1], n1[PW-1], n0[PW-1]};
        item_next.num_mag[0] = mag_of(n0);
        item_next.num_mag[1] = mag_of(n1);
        item_next.num_mag[2] = mag_of(n2);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

[hdl/qfr_fifo.sv]
// Short queue of classified items between the front end and the arithmetic back end.
module qfr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  qfr_pkg::cls_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output qfr_pkg::cls_item_t   pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qfr_pkg::cls_item_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push_fire, pop_fire;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push_fire && !pop_fire)
            count_next = count_reg + CNT_W'(1);
        else if (pop_fire && !push_fire)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
            mem[wr_ptr_reg] <= push_item;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !push_fire |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count missed a pop");

endmodule

[hdl/qfr_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband carried along.
module qfr_isqrt #(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      radicand,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int RW = IN_W / 2;

    logic              v_reg    [RW];
    logic [IN_W-1:0]   x_reg    [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic              v_in;
        logic [IN_W-1:0]   x_in, x_next;
        logic [RW+1:0]     rem_in, rem_sh, trial, rem_next;
        logic [RW-1:0]     root_in, root_next;
        logic [SIDE_W-1:0] side_in;
        logic              ge;

        if (s == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_body
            assign v_in    = v_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Bring down two radicand bits and try root*4+1
        assign rem_sh    = {rem_in[RW-1:0], x_in[IN_W-1 -: 2]};
        assign trial     = {root_in, 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[RW-2:0], ge};
        assign x_next    = x_in << 2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

[hdl/qfr_div.sv]
// Pipelined unsigned restoring divider, several lanes sharing one divisor, one bit per stage.
module qfr_div #(
    parameter int N_W    = 31,
    parameter int D_W    = 17,
    parameter int Q_W    = 23,
    parameter int LANES  = 3,
    parameter int SIDE_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][N_W-1:0]   dividend,
    input  logic [D_W-1:0]              divisor,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   quotient,
    output logic [SIDE_W-1:0]           out_side
);

    // The quotient fits Q_W bits, so the top dividend bits start as the remainder.
    logic                      v_reg    [Q_W];
    logic [D_W-1:0]            den_reg  [Q_W];
    logic [LANES-1:0][D_W-1:0] rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0] low_reg  [Q_W];
    logic [SIDE_W-1:0]         side_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic                      v_in;
        logic [D_W-1:0]            den_in;
        logic [LANES-1:0][D_W-1:0] rem_in, rem_next;
        logic [LANES-1:0][Q_W-1:0] low_in, low_next;
        logic [SIDE_W-1:0]         side_in;
        logic [D_W:0]              rem_sh, diff;
        logic                      ge;

        if (s == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign den_in  = divisor;
            assign side_in = in_side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign rem_in[l] = D_W'(dividend[l][N_W-1:Q_W]);
                assign low_in[l] = dividend[l][Q_W-1:0];
            end
        end
        else
        begin : g_body
            assign v_in    = v_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign low_in  = low_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Shift in the next dividend bit and subtract where it fits
        always_comb
        begin
            rem_sh = '0;
            diff   = '0;
            ge     = 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                rem_sh      = {rem_in[l], low_in[l][Q_W-1]};
                diff        = rem_sh - {1'b0, den_in};
                ge          = rem_sh >= {1'b0, den_in};
                rem_next[l] = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
                low_next[l] = {low_in[l][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s]  <= den_in;
                rem_reg[s]  <= rem_next;
                low_reg[s]  <= low_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quotient  = low_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[hdl/qfr_back.sv]
// Back end: root, divides, normalization and the output register.
module qfr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  qfr_pkg::cls_item_t                in_item,
    input  logic [qfr_pkg::LIMIT_SQ_W-1:0]    limit_sq,
    output logic                              out_valid,
    input  logic                              out_ready,
    output qfr_pkg::out_item_t                out_item
);

    localparam int CW  = qfr_pkg::COMP_W;
    localparam int NW  = qfr_pkg::NORM_W;
    localparam int FB  = qfr_pkg::FRAC_BITS;
    localparam int DW  = qfr_pkg::DATA_WIDTH;

    typedef struct packed {
        logic [1:0]               case_taken;
        logic [2:0]               num_neg;
        logic [qfr_pkg::SQ_W-2:0] dom;
        logic                     zero_div;
    } s2_t;

    typedef struct packed {
        logic [3:0][NW-1:0] mag;
        logic [3:0]         neg;
        logic [1:0]         case_taken;
        logic               degen;
    } s4_t;

    typedef struct packed {
        logic [3:0] neg;
        logic [1:0] case_taken;
        logic       degen;
    } s5_t;

    logic en;

    // First root
    logic                       r1_valid;
    logic [qfr_pkg::SQ_W-1:0]   r1_root;
    logic [$bits(qfr_pkg::cls_item_t)-1:0] r1_side_v;
    qfr_pkg::cls_item_t         r1_side;

    // First divide
    logic [2:0][qfr_pkg::DIV1_N_W-1:0] d1_num;
    s2_t                        d1_in_side, d1_side;
    logic [$bits(s2_t)-1:0]     d1_side_v;
    logic                       d1_valid;
    logic [2:0][CW-1:0]         d1_quot;

    // Normalization stages
    logic                       a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic [3:0][CW-1:0]         a_mag_reg, a_mag_next, b_mag_reg;
    logic [3:0]                 a_neg_reg, a_neg_next, b_neg_reg, c_neg_reg, d_neg_reg;
    logic [1:0]                 a_case_reg, b_case_reg, c_case_reg, d_case_reg;
    logic                       a_zdiv_reg, b_zdiv_reg, c_degen_reg, c_degen_next, d_degen_reg;
    logic [3:0][2*CW-1:0]       b_sq_reg;
    logic [qfr_pkg::SH_W-1:0]   b_shift_reg, b_shift_next, b_msb;
    logic                       b_zero_reg;
    logic [CW-1:0]              b_or;
    logic [3:0][NW-1:0]         c_mag_reg, c_mag_next, d_mag_reg;
    logic [qfr_pkg::SSUM1_W-1:0] c_ssum;
    logic [3:0][2*NW-1:0]       d_sq_reg;
    logic [qfr_pkg::NSUM_W-1:0] e_sum_reg;
    s4_t                        e_side_reg;
    logic [1:0]                 dom_idx, lane;

    // Second root and divide
    logic                       r2_valid;
    logic [qfr_pkg::NRM_W-1:0]  r2_root;
    logic [$bits(s4_t)-1:0]     r2_side_v;
    s4_t                        r2_side;
    logic [3:0][qfr_pkg::DIV2_N_W-1:0] d2_num;
    s5_t                        d2_in_side, d2_side;
    logic [$bits(s5_t)-1:0]     d2_side_v;
    logic                       d2_valid;
    logic [3:0][qfr_pkg::DIV2_Q_W-1:0] d2_quot;

    // Output
    logic                       out_valid_reg;
    qfr_pkg::out_item_t         out_item_reg, out_item_next;
    logic [3:0][DW-1:0]         comp;

    // The whole back end advances together when the output register can take an item
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    qfr_isqrt #(
        .IN_W   (qfr_pkg::SQ_IN_W),
        .SIDE_W ($bits(qfr_pkg::cls_item_t))
    ) u_root1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .radicand  (qfr_pkg::SQ_IN_W'({in_item.arg, {FB{1'b0}}})),
        .in_side   (in_item),
        .out_valid (r1_valid),
        .root      (r1_root),
        .out_side  (r1_side_v)
    );

    assign r1_side = r1_side_v;

    // Numerators times ONE, divided by twice the root
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            d1_num[l] = {r1_side.num_mag[l], {FB{1'b0}}};
        d1_in_side.case_taken = r1_side.case_taken;
        d1_in_side.num_neg    = r1_side.num_neg;
        d1_in_side.dom        = r1_root[qfr_pkg::SQ_W-1:1];
        d1_in_side.zero_div   = r1_root == '0;
    end

    qfr_div #(
        .N_W    (qfr_pkg::DIV1_N_W),
        .D_W    (qfr_pkg::DEN_W),
        .Q_W    (qfr_pkg::DIV1_Q_W),
        .LANES  (3),
        .SIDE_W ($bits(s2_t))
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r1_valid),
        .dividend  (d1_num),
        .divisor   ({r1_root, 1'b0}),
        .in_side   (d1_in_side),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .out_side  (d1_side_v)
    );

    assign d1_side = d1_side_v;

    // Place the dominant half-root and the three quotients into x, y, z, w
    always_comb
    begin
        dom_idx = (d1_side.case_taken == qfr_pkg::CASE_TRACE) ? 2'd3
                                                              : d1_side.case_taken - 2'd1;
        lane = '0;
        for (int k = 0; k < 4; k++)
        begin
            lane = (2'(k) < dom_idx) ? 2'(k) : 2'(k) - 2'd1;
            if (2'(k) == dom_idx)
            begin
                a_mag_next[k] = CW'(d1_side.dom);
                a_neg_next[k] = 1'b0;
            end
            else
            begin
                a_mag_next[k] = d1_quot[lane];
                a_neg_next[k] = d1_side.num_neg[lane];
            end
        end
    end

    // Highest set bit of the largest magnitude, from the OR of all four
    always_comb
    begin
        b_or  = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2] | a_mag_reg[3];
        b_msb = '0;
        for (int i = 0; i < CW; i++)
            if (b_or[i])
                b_msb = qfr_pkg::SH_W'(i);
        b_shift_next = qfr_pkg::SH_W'(NW - 1) - b_msb;
    end

    // Near-zero test and scaling of the largest magnitude to the top bit
    always_comb
    begin
        c_ssum = qfr_pkg::SSUM1_W'(b_sq_reg[0]) + qfr_pkg::SSUM1_W'(b_sq_reg[1])
               + qfr_pkg::SSUM1_W'(b_sq_reg[2]) + qfr_pkg::SSUM1_W'(b_sq_reg[3]);
        c_degen_next = b_zdiv_reg || b_zero_reg
                    || (c_ssum < qfr_pkg::SSUM1_W'(limit_sq));
        for (int k = 0; k < 4; k++)
            c_mag_next[k] = NW'(b_mag_reg[k]) << b_shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= d1_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg   <= a_mag_next;
            a_neg_reg   <= a_neg_next;
            a_case_reg  <= d1_side.case_taken;
            a_zdiv_reg  <= d1_side.zero_div;

            for (int k = 0; k < 4; k++)
                b_sq_reg[k] <= a_mag_reg[k] * a_mag_reg[k];
            b_mag_reg   <= a_mag_reg;
            b_neg_reg   <= a_neg_reg;
            b_case_reg  <= a_case_reg;
            b_zdiv_reg  <= a_zdiv_reg;
            b_shift_reg <= b_shift_next;
            b_zero_reg  <= b_or == '0;

            c_mag_reg   <= c_mag_next;
            c_neg_reg   <= b_neg_reg;
            c_case_reg  <= b_case_reg;
            c_degen_reg <= c_degen_next;

            for (int k = 0; k < 4; k++)
                d_sq_reg[k] <= c_mag_reg[k] * c_mag_reg[k];
            d_mag_reg   <= c_mag_reg;
            d_neg_reg   <= c_neg_reg;
            d_case_reg  <= c_case_reg;
            d_degen_reg <= c_degen_reg;

            e_sum_reg   <= qfr_pkg::NSUM_W'(d_sq_reg[0]) + qfr_pkg::NSUM_W'(d_sq_reg[1])
                         + qfr_pkg::NSUM_W'(d_sq_reg[2]) + qfr_pkg::NSUM_W'(d_sq_reg[3]);
            e_side_reg.mag        <= d_mag_reg;
            e_side_reg.neg        <= d_neg_reg;
            e_side_reg.case_taken <= d_case_reg;
            e_side_reg.degen      <= d_degen_reg;
        end
    end

    qfr_isqrt #(
        .IN_W   (qfr_pkg::NSUM_W),
        .SIDE_W ($bits(s4_t))
    ) u_root2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .radicand  (e_sum_reg),
        .in_side   (e_side_reg),
        .out_valid (r2_valid),
        .root      (r2_root),
        .out_side  (r2_side_v)
    );

    assign r2_side = r2_side_v;

    // Scaled magnitudes times ONE over the norm
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            d2_num[k] = {r2_side.mag[k], {FB{1'b0}}};
        d2_in_side.neg        = r2_side.neg;
        d2_in_side.case_taken = r2_side.case_taken;
        d2_in_side.degen      = r2_side.degen;
    end

    qfr_div #(
        .N_W    (qfr_pkg::DIV2_N_W),
        .D_W    (qfr_pkg::NRM_W),
        .Q_W    (qfr_pkg::DIV2_Q_W),
        .LANES  (4),
        .SIDE_W ($bits(s5_t))
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r2_valid),
        .dividend  (d2_num),
        .divisor   (r2_root),
        .in_side   (d2_in_side),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .out_side  (d2_side_v)
    );

    assign d2_side = d2_side_v;

    // Signs back on; identity for a degenerate item (quotient never exceeds ONE)
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            comp[k] = d2_side.neg[k] ? -DW'(d2_quot[k]) : DW'(d2_quot[k]);
        out_item_next.case_taken = d2_side.case_taken;
        out_item_next.degenerate = d2_side.degen;
        if (d2_side.degen)
        begin
            out_item_next.quat_x = '0;
            out_item_next.quat_y = '0;
            out_item_next.quat_z = '0;
            out_item_next.quat_w = qfr_pkg::QUAT_ONE;
        end
        else
        begin
            out_item_next.quat_x = comp[0];
            out_item_next.quat_y = comp[1];
            out_item_next.quat_z = comp[2];
            out_item_next.quat_w = comp[3];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.degenerate |->
            out_item_reg.quat_x == '0 && out_item_reg.quat_y == '0
            && out_item_reg.quat_z == '0 && out_item_reg.quat_w == qfr_pkg::QUAT_ONE)
        else $error("degenerate item is not the identity");

    a_trace_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.degenerate
            && out_item_reg.case_taken == qfr_pkg::CASE_TRACE |->
            !out_item_reg.quat_w[DW-1])
        else $error("trace case gave a negative scalar part");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("waiting result changed before it was taken");

endmodule

[hdl/quaternion_from_rotation_matrix_top.sv]
// Top level: rotation matrix in, normalized quaternion out, Shepperd's method in Q1.14.
//
//  channel  | signals                       | transfer
//  ---------+-------------------------------+----------------------------------
//  in       | in_valid, in_ready, in_item   | nine matrix entries per item
//  out      | out_valid, out_ready, out_item| quaternion, case, degenerate flag
//  cfg      | cfg_write, cfg_data           | near-zero norm limit, no wait
//
// One item per cycle sustained when the output is not stalled. The arithmetic runs
// through the two one-bit-per-stage square roots (16 and 32 stages) and the two
// one-bit-per-stage dividers (23 and 15 stages).
// Reset clears all valid bits and sets the limit to 1; nothing else needs clearing.
// A stalled output freezes the whole arithmetic back end; the queue of FIFO_DEPTH items
// behind the classifier keeps taking items until it fills.
module quaternion_from_rotation_matrix_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  qfr_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output qfr_pkg::out_item_t             out_item,
    input  logic                           cfg_write,
    input  logic [qfr_pkg::LIMIT_W-1:0]    cfg_data
);

    logic [qfr_pkg::LIMIT_W-1:0]    limit_reg;
    logic [qfr_pkg::LIMIT_SQ_W-1:0] limit_sq_reg;

    logic               cls_valid, cls_ready;
    qfr_pkg::cls_item_t cls_item;
    logic               q_valid, q_ready;
    qfr_pkg::cls_item_t q_item;

    // Limit register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= qfr_pkg::LIMIT_W'(1);
            limit_sq_reg <= qfr_pkg::LIMIT_SQ_W'(1);
        end
        else
        begin
            if (cfg_write)
                limit_reg <= cfg_data;
            limit_sq_reg <= limit_reg * limit_reg;
        end
    end

    qfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_item  (cls_item)
    );

    qfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_ready (cls_ready),
        .push_item  (cls_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    qfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .limit_sq  (limit_sq_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

[sim/tb_quaternion_from_rotation_matrix_top.sv]
// Testbench for the quaternion-from-rotation-matrix block: directed table, random items, self-check.
module tb_quaternion_from_rotation_matrix_top;

    localparam int  NUM_RANDOM  = 1730;
    localparam int  DRAIN_WAIT  = 120;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam longint ONE_Q   = longint'(1) << qfr_pkg::FRAC_BITS;
    localparam int  DW         = qfr_pkg::DATA_WIDTH;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    qfr_pkg::in_item_t           in_item;
    logic                        out_valid;
    logic                        out_ready;
    qfr_pkg::out_item_t          out_item;
    logic                        cfg_write;
    logic [qfr_pkg::LIMIT_W-1:0] cfg_data;

    quaternion_from_rotation_matrix_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Predictor state and result store
    longint unsigned    norm_limit;
    qfr_pkg::out_item_t quat_expected_q[$];
    int                 mismatch_cnt;
    int                 items_sent;
    int                 results_seen;
    int                 degen_seen;
    int                 case_seen [4];
    bit                 no_gaps;
    longint             cycle_cnt;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Shepperd's method with normalization, exact wide arithmetic
    function automatic qfr_pkg::out_item_t predict_quat(qfr_pkg::in_item_t it);
        longint             a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint             tr, arg, den;
        longint             q [4];
        longint unsigned    mag [4];
        longint unsigned    sq, big, ssum, nrm, v, maxpos;
        logic [1:0]         cs;
        bit                 degen;
        qfr_pkg::out_item_t r;
        a00 = it.m00; a01 = it.m01; a02 = it.m02;
        a10 = it.m10; a11 = it.m11; a12 = it.m12;
        a20 = it.m20; a21 = it.m21; a22 = it.m22;
        tr = a00 + a11 + a22;
        q = '{0, 0, 0, 0};
        degen = 1'b0;
        if (tr > 0)
        begin
            cs = qfr_pkg::CASE_TRACE; arg = ONE_Q + tr;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            cs = qfr_pkg::CASE_X; arg = ONE_Q + a00 - a11 - a22;
        end
        else if (a11 > a22)
        begin
            cs = qfr_pkg::CASE_Y; arg = ONE_Q + a11 - a00 - a22;
        end
        else
        begin
            cs = qfr_pkg::CASE_Z; arg = ONE_Q + a22 - a00 - a11;
        end
        if (arg < 0)
            arg = 0;
        sq = int_sqrt(longint'(arg) << qfr_pkg::FRAC_BITS);
        if (sq == 0)
            degen = 1'b1;
        else
        begin
            den = 2 * longint'(sq);
            case (cs)
                qfr_pkg::CASE_TRACE:
                begin
                    q[3] = sq >> 1;
                    q[0] = ((a21 - a12) * ONE_Q) / den;
                    q[1] = ((a02 - a20) * ONE_Q) / den;
                    q[2] = ((a10 - a01) * ONE_Q) / den;
                end
                qfr_pkg::CASE_X:
                begin
                    q[3] = ((a21 - a12) * ONE_Q) / den;
                    q[0] = sq >> 1;
                    q[1] = ((a01 + a10) * ONE_Q) / den;
                    q[2] = ((a02 + a20) * ONE_Q) / den;
                end
                qfr_pkg::CASE_Y:
                begin
                    q[3] = ((a02 - a20) * ONE_Q) / den;
                    q[0] = ((a01 + a10) * ONE_Q) / den;
                    q[1] = sq >> 1;
                    q[2] = ((a12 + a21) * ONE_Q) / den;
                end
                default:
                begin
                    q[3] = ((a10 - a01) * ONE_Q) / den;
                    q[0] = ((a02 + a20) * ONE_Q) / den;
                    q[1] = ((a12 + a21) * ONE_Q) / den;
                    q[2] = sq >> 1;
                end
            endcase
        end
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
            if (mag[i] > big)
                big = mag[i];
        end
        // near-zero norm test only applies while the sum of squares cannot overflow
        if (!degen)
        begin
            if (big == 0)
                degen = 1'b1;
            else if (big < (longint'(1) << 31))
            begin
                ssum = 0;
                for (int i = 0; i < 4; i++)
                    ssum += mag[i] * mag[i];
                if (ssum < norm_limit * norm_limit)
                    degen = 1'b1;
            end
        end
        r.case_taken = cs;
        r.degenerate = degen;
        if (degen)
        begin
            r.quat_x = '0; r.quat_y = '0; r.quat_z = '0;
            r.quat_w = qfr_pkg::QUAT_ONE;
            return r;
        end
        while (big < (longint'(1) << 30))
        begin
            for (int i = 0; i < 4; i++)
                mag[i] = mag[i] << 1;
            big = big << 1;
        end
        while (big >= (longint'(1) << 31))
        begin
            for (int i = 0; i < 4; i++)
                mag[i] = mag[i] >> 1;
            big = big >> 1;
        end
        ssum = 0;
        for (int i = 0; i < 4; i++)
            ssum += mag[i] * mag[i];
        nrm = int_sqrt(ssum);
        maxpos = (longint'(1) << (DW - 1)) - 1;
        for (int i = 0; i < 4; i++)
        begin
            v = (mag[i] * longint'(ONE_Q)) / nrm;
            if (v > maxpos)
                v = maxpos;
            if (q[i] < 0)
                v = -v;
            case (i)
                0: r.quat_x = v[DW-1:0];
                1: r.quat_y = v[DW-1:0];
                2: r.quat_z = v[DW-1:0];
                default: r.quat_w = v[DW-1:0];
            endcase
        end
        return r;
    endfunction

    function automatic qfr_pkg::in_item_t make_matrix(longint e00, longint e01, longint e02,
                                                      longint e10, longint e11, longint e12,
                                                      longint e20, longint e21, longint e22);
        qfr_pkg::in_item_t it;
        it.m00 = e00[DW-1:0]; it.m01 = e01[DW-1:0];
        it.m02 = e02[DW-1:0]; it.m10 = e10[DW-1:0];
        it.m11 = e11[DW-1:0]; it.m12 = e12[DW-1:0];
        it.m20 = e20[DW-1:0]; it.m21 = e21[DW-1:0];
        it.m22 = e22[DW-1:0];
        return it;
    endfunction

    // Rotation matrix built from a random unnormalized quaternion, optional noise
    function automatic qfr_pkg::in_item_t random_rotation(int span, int noise);
        longint w, x, y, z, n2;
        longint e [9];
        w = $signed($urandom_range(0, 2 * span)) - span;
        x = $signed($urandom_range(0, 2 * span)) - span;
        y = $signed($urandom_range(0, 2 * span)) - span;
        z = $signed($urandom_range(0, 2 * span)) - span;
        n2 = w*w + x*x + y*y + z*z;
        if (n2 == 0)
        begin
            w = 1; n2 = 1;
        end
        e[0] = w*w + x*x - y*y - z*z;  e[1] = 2*(x*y - w*z);  e[2] = 2*(x*z + w*y);
        e[3] = 2*(x*y + w*z);  e[4] = w*w - x*x + y*y - z*z;  e[5] = 2*(y*z - w*x);
        e[6] = 2*(x*z - w*y);  e[7] = 2*(y*z + w*x);  e[8] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 9; i++)
            e[i] = (e[i] * ONE_Q) / n2 + ($signed($urandom_range(0, 2 * noise)) - noise);
        return make_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    endfunction

    function automatic qfr_pkg::in_item_t random_item();
        int         sel;
        logic [159:0] raw;
        sel = $urandom_range(0, 99);
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if (sel < 45)
            return random_rotation(1000, 0);
        else if (sel < 65)
            return random_rotation($urandom_range(1, 40), $urandom_range(0, 300));
        else if (sel < 85)
            return qfr_pkg::in_item_t'(raw[$bits(qfr_pkg::in_item_t)-1:0]);
        else
            return make_matrix($signed($urandom_range(0, 32768)) - 16384,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 32768)) - 16384,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 64)) - 32,
                               $signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int sel;
        if (no_gaps)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Drive one item, hold until accepted, then queue its prediction
    task automatic send_matrix(qfr_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        quat_expected_q.push_back(predict_quat(it));
        items_sent++;
    endtask

    // Hold off input until every pending result is back, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (quat_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_limit(longint unsigned value);
        cfg_write <= 1'b1;
        cfg_data  <= value[qfr_pkg::LIMIT_W-1:0];
        @(posedge clk);
        norm_limit = value & 64'h7FFF;
        cfg_write <= 1'b0;
    endtask

    // Output side: random stalls
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left > 0 && !no_gaps)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        qfr_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (quat_expected_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: %p", out_item);
            end
            else
            begin
                want = quat_expected_q.pop_front();
                case_seen[out_item.case_taken]++;
                if (out_item.degenerate)
                    degen_seen++;
                if (out_item.quat_x !== want.quat_x || out_item.quat_y !== want.quat_y ||
                    out_item.quat_z !== want.quat_z || out_item.quat_w !== want.quat_w ||
                    out_item.case_taken !== want.case_taken ||
                    out_item.degenerate !== want.degenerate)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d c=%0d d=%0d",
                                 want.quat_x, want.quat_y, want.quat_z, want.quat_w,
                                 want.case_taken, want.degenerate);
                        $display("          actual   x=%0d y=%0d z=%0d w=%0d c=%0d d=%0d",
                                 out_item.quat_x, out_item.quat_y, out_item.quat_z,
                                 out_item.quat_w, out_item.case_taken,
                                 out_item.degenerate);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Directed table: matrix, and a typed result where it is obvious
    qfr_pkg::in_item_t  dir_mat [$];
    bit                 dir_has [$];
    qfr_pkg::out_item_t dir_want [$];

    task automatic add_row(qfr_pkg::in_item_t it, bit has, qfr_pkg::out_item_t want);
        dir_mat.push_back(it);
        dir_has.push_back(has);
        dir_want.push_back(want);
    endtask

    initial
    begin
        qfr_pkg::out_item_t ident;
        qfr_pkg::out_item_t none;
        longint unsigned    limits [5];
        longint             one;
        one = ONE_Q;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_ready  = 1'b0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        stall_left = 0;
        cycle_cnt  = 0;
        no_gaps    = 1'b0;
        mismatch_cnt = 0;
        items_sent = 0;
        results_seen = 0;
        degen_seen = 0;
        case_seen  = '{0, 0, 0, 0};
        norm_limit = 1;
        ident = '{quat_x: 0, quat_y: 0, quat_z: 0, quat_w: qfr_pkg::QUAT_ONE,
                  case_taken: qfr_pkg::CASE_TRACE, degenerate: 1'b0};
        none = '0;

        // identity, zeros, saturated entries, half turns, quarter turns
        add_row(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one), 1'b1, ident);
        add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(make_matrix(one, one, one, one, one, one, one, one, one), 1'b0, none);
        add_row(make_matrix(-one, -one, -one, -one, -one, -one, -one, -one, -one), 1'b0, none);
        add_row(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                1'b0, none);
        add_row(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768), 1'b0, none);
        add_row(make_matrix(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                            -32768), 1'b0, none);
        add_row(make_matrix(one, 0, 0, 0, -one, 0, 0, 0, -one), 1'b0, none);
        add_row(make_matrix(-one, 0, 0, 0, one, 0, 0, 0, -one), 1'b0, none);
        add_row(make_matrix(-one, 0, 0, 0, -one, 0, 0, 0, one), 1'b0, none);
        add_row(make_matrix(0, -one, 0, one, 0, 0, 0, 0, one), 1'b0, none);
        add_row(make_matrix(one, 0, 0, 0, 0, -one, 0, one, 0), 1'b0, none);
        add_row(make_matrix(0, 0, one, 0, one, 0, -one, 0, 0), 1'b0, none);
        // ties on the diagonal, non-positive trace
        add_row(make_matrix(-5461, 100, -100, 50, -5461, 7, 9, -3, -5461), 1'b0, none);
        add_row(make_matrix(-one, 0, 0, 0, -one, 0, 0, 0, -one), 1'b0, none);
        // non-orthogonal: one matrix in the x case, one in the trace case
        add_row(make_matrix(16000, 0, 0, 0, 15999, 0, 0, 0, -32768), 1'b0, none);
        add_row(make_matrix(-16384, 200, 300, -400, 32767, 500, 600, 700, 32766), 1'b0, none);
        // alternating bit patterns, then small entries
        add_row(qfr_pkg::in_item_t'({9{16'h5555}}), 1'b0, none);
        add_row(qfr_pkg::in_item_t'({9{16'hAAAA}}), 1'b0, none);
        add_row(make_matrix(3, -2, 1, 2, 3, -1, -1, 1, 3), 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit, typed results pushed in place of predictions
        for (int i = 0; i < dir_mat.size(); i++)
        begin
            send_matrix(dir_mat[i]);
            if (dir_has[i])
                quat_expected_q[quat_expected_q.size() - 1] = dir_want[i];
        end
        wait_drained();

        // Random phases over several limits, extremes among them
        limits = '{0, 16384, 200, 1 + $urandom_range(0, 3000), 1};
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            no_gaps = (p == 2);
            for (int i = 0; i < NUM_RANDOM / 5; i++)
                send_matrix(random_item());
            wait_drained();
        end
        no_gaps = 1'b0;

        $display("%0d matrices sent over 6 limit settings, %0d results, %0d degenerate",
                 items_sent, results_seen, degen_seen);
        $display("cases seen: trace %0d, x %0d, y %0d, z %0d",
                 case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
        if (mismatch_cnt == 0 && quat_expected_q.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     quat_expected_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
hdl/qfr_pkg.sv
hdl/qfr_front.sv
hdl/qfr_fifo.sv
hdl/qfr_isqrt.sv
hdl/qfr_div.sv
hdl/qfr_back.sv
hdl/quaternion_from_rotation_matrix_top.sv
sim/tb_quaternion_from_rotation_matrix_top.sv
